/* rtl/core/stbs_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the table search block.
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int ENTRY_INDEX_BITS = 10;
    localparam int WORD_BITS        = 32;
    localparam int COUNT_BITS       = 11;
    localparam int POSITION_BITS    = 10;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic write_en;
        logic load_search;
        logic probe_en;
        logic go_left;
        logic go_right;
        logic set_hit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic range_open;
        logic key_eq;
        logic key_lt;
    } t_dp_stat;

endpackage

/* rtl/core/stbs_ctrl.sv */
// Controller state machine sequencing writes, probes and the result register.
module stbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  stbs_pkg::t_dp_stat i_stat,
    output stbs_pkg::t_dp_cmd  o_dp_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    stbs_pkg::t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == stbs_pkg::CMD_SEARCH) begin
                        w_cmd.load_search = 1'b1;
                        n_state           = ST_PROBE;
                    end else begin
                        w_cmd.write_en = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (i_stat.range_open) begin
                    w_cmd.probe_en = 1'b1;
                    n_state        = ST_CMP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_CMP: begin
                priority if (i_stat.key_eq) begin
                    w_cmd.set_hit = 1'b1;
                    n_state       = ST_FIN;
                end else if (i_stat.key_lt) begin
                    w_cmd.go_left = 1'b1;
                    n_state       = ST_PROBE;
                end else begin
                    w_cmd.go_right = 1'b1;
                    n_state        = ST_PROBE;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dp_cmd    = w_cmd;

endmodule

/* rtl/core/stbs_dp.sv */
// Datapath: value memory, search bounds, key compare and result register.
module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = stbs_pkg::VALUE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_valid,
    input  logic [stbs_pkg::COUNT_BITS-1:0]            i_cfg_entry_count,
    input  logic [stbs_pkg::ENTRY_INDEX_BITS-1:0]      i_entry_index,
    input  logic signed [stbs_pkg::WORD_BITS-1:0]      i_entry_value,
    input  logic signed [stbs_pkg::WORD_BITS-1:0]      i_search_key,
    input  stbs_pkg::t_dp_cmd                          i_cmd,
    output stbs_pkg::t_dp_stat                         o_stat,
    output logic                                       o_found,
    output logic [stbs_pkg::POSITION_BITS-1:0]         o_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [VALUE_BITS-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] r_rdata;
    logic signed [VALUE_BITS-1:0] r_key;
    logic [stbs_pkg::COUNT_BITS-1:0] r_entry_count;
    logic [CW-1:0]                r_lo;
    logic [CW-1:0]                r_hi_p1;
    logic [AW-1:0]                r_mid;
    logic                         r_hit;
    logic                         r_found;
    logic [stbs_pkg::POSITION_BITS-1:0] r_position;

    logic signed [63:0]           w_value_ext;
    logic signed [63:0]           w_key_ext;
    logic [31:0]                  w_index_ext;
    logic                         w_index_ok;
    logic [31:0]                  w_count_ext;
    logic [CW-1:0]                w_count;
    logic [CW:0]                  w_mid_sum;
    logic [CW:0]                  w_mid_half;
    logic [AW-1:0]                w_mid;
    logic [31:0]                  w_mid_ext;

    assign w_value_ext = 64'(i_entry_value);
    assign w_key_ext   = 64'(i_search_key);
    assign w_index_ext = 32'(i_entry_index);
    assign w_index_ok  = (w_index_ext < 32'(TABLE_DEPTH));
    assign w_count_ext = 32'(r_entry_count);
    assign w_count     = (w_count_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                          : w_count_ext[CW-1:0];
    assign w_mid_sum   = (CW+1)'(r_lo) + (CW+1)'(r_hi_p1) - (CW+1)'(1);
    assign w_mid_half  = w_mid_sum >> 1;
    assign w_mid       = w_mid_half[AW-1:0];
    assign w_mid_ext   = 32'(r_mid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_en && w_index_ok) begin
            r_mem[w_index_ext[AW-1:0]] <= w_value_ext[VALUE_BITS-1:0];
        end
        if (i_cmd.probe_en) begin
            r_rdata <= r_mem[w_mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= stbs_pkg::COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_entry_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_search) begin
            r_key   <= w_key_ext[VALUE_BITS-1:0];
            r_lo    <= '0;
            r_hi_p1 <= w_count;
            r_hit   <= 1'b0;
        end
        if (i_cmd.probe_en) begin
            r_mid <= w_mid;
        end
        if (i_cmd.go_left) begin
            r_hi_p1 <= CW'(r_mid);
        end
        if (i_cmd.go_right) begin
            r_lo <= CW'(r_mid) + CW'(1);
        end
        if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_found    <= r_hit;
            r_position <= r_hit ? w_mid_ext[stbs_pkg::POSITION_BITS-1:0] : '0;
        end
    end

    assign o_stat.range_open = (r_lo < r_hi_p1);
    assign o_stat.key_eq     = (r_rdata == r_key);
    assign o_stat.key_lt     = (r_key < r_rdata);
    assign o_found           = r_found;
    assign o_position        = r_position;

endmodule

/* rtl/core/sorted_table_binary_search.sv */
// Top level of the sorted table binary search block.
// Holds TABLE_DEPTH signed values that software keeps in ascending order. A write word
// (cmd 0) stores entry_value at entry_index and gives no result; indexes at or beyond
// TABLE_DEPTH are dropped. A search word (cmd 1) bisects positions 0 to
// min(entry_count, TABLE_DEPTH)-1 and returns one result word with found and position
// (position 0 on a miss). A search makes at most ceil(log2(n+1)) probes for n searched
// entries. Each probe does a registered read of the value memory in the probe state and
// the key compare in the compare state; a hit or an empty range ends the search in the
// finish state, which loads the result register. The input stalls from the search
// until its result is loaded and takes the next word in the cycle after, so no new word
// is taken while a search is in progress; writes do not stall the input. A finished
// result waits while an earlier result is still stalled at the output, holding the input
// stalled with it; once loaded, the block takes the next word while that result still
// waits. The user must write entry_count through the config channel only while the
// block is idle; the block itself does not enforce it. entry_count resets to 1024.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = stbs_pkg::VALUE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [stbs_pkg::COUNT_BITS-1:0]        i_cfg_entry_count,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_cmd,
    input  logic [stbs_pkg::ENTRY_INDEX_BITS-1:0]  i_entry_index,
    input  logic signed [stbs_pkg::WORD_BITS-1:0]  i_entry_value,
    input  logic signed [stbs_pkg::WORD_BITS-1:0]  i_search_key,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_found,
    output logic [stbs_pkg::POSITION_BITS-1:0]     o_position
);

    stbs_pkg::t_dp_cmd  w_dp_cmd;
    stbs_pkg::t_dp_stat w_dp_stat;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_dp_stat),
        .o_dp_cmd    (w_dp_cmd)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_entry_count (i_cfg_entry_count),
        .i_entry_index     (i_entry_index),
        .i_entry_value     (i_entry_value),
        .i_search_key      (i_search_key),
        .i_cmd             (w_dp_cmd),
        .o_stat            (w_dp_stat),
        .o_found           (o_found),
        .o_position        (o_position)
    );

endmodule

/* rtl/core/stbs_checker.sv */
// Port-level checker for the table search block and its bind.
module stbs_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   i_cmd,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic                                   o_found,
    input logic [stbs_pkg::POSITION_BITS-1:0]     o_position
);

    logic w_in_take;

    assign w_in_take = i_in_valid && !o_in_stall;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_miss_position_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_position == '0)
        else $error("miss with nonzero position");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && i_cmd == stbs_pkg::CMD_WRITE && !o_out_valid |=> !o_out_valid)
        else $error("write word produced a result");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && i_cmd == stbs_pkg::CMD_SEARCH |=> o_in_stall)
        else $error("input not stalled during search");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_found) && $stable(o_position))
        else $error("stalled result changed");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_found     (o_found),
    .o_position  (o_position)
);

/* dv/stbs_search_checker.sv */
// Checker for the sorted table search block: mirrors the table, bisects searches, compares.
module stbs_search_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [stbs_pkg::COUNT_BITS-1:0]        i_cfg_entry_count,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic                                   i_cmd,
    input  logic [stbs_pkg::ENTRY_INDEX_BITS-1:0]  i_entry_index,
    input  logic signed [stbs_pkg::WORD_BITS-1:0]  i_entry_value,
    input  logic signed [stbs_pkg::WORD_BITS-1:0]  i_search_key,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic                                   i_found,
    input  logic [stbs_pkg::POSITION_BITS-1:0]     i_position,
    input  logic                                   i_end_of_test,
    output int                                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                               found;
        logic [stbs_pkg::POSITION_BITS-1:0] position;
    } t_search_result;

    logic signed [stbs_pkg::WORD_BITS-1:0] stored_values [stbs_pkg::TABLE_DEPTH_DEF];
    logic [stbs_pkg::COUNT_BITS-1:0]       entry_count_q;
    t_search_result                        pending_results [$];
    bit                                    end_seen;

    function automatic t_search_result bisect_table(
        input logic signed [stbs_pkg::WORD_BITS-1:0] key
    );
        int             lo;
        int             hi;
        int             mid;
        int             span;
        t_search_result res;
        res = '0;
        span = entry_count_q;
        if (span > stbs_pkg::TABLE_DEPTH_DEF) begin
            span = stbs_pkg::TABLE_DEPTH_DEF;
        end
        lo = 0;
        hi = span - 1;
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (stored_values[mid] == key) begin
                res.found = 1'b1;
                res.position = mid[stbs_pkg::POSITION_BITS-1:0];
            end else if (key < stored_values[mid]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_search_result want;
        if (!i_rst_n) begin
            entry_count_q = stbs_pkg::COUNT_RESET;
            pending_results.delete();
            o_fail_count = 0;
            end_seen = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with none expected: found=%0b position=%0d",
                             $time, i_found, i_position);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, i_found);
                        o_fail_count++;
                    end
                    if (i_position !== want.position) begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, i_position);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                entry_count_q = i_cfg_entry_count;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == stbs_pkg::CMD_WRITE) begin
                    stored_values[i_entry_index] = i_entry_value;
                end else begin
                    pending_results.push_back(bisect_table(i_search_key));
                end
            end
            if (i_end_of_test && !end_seen) begin
                end_seen = 1'b1;
                if (pending_results.size() != 0) begin
                    $display("%0t: %0d result words never arrived: expected %0d, actual 0",
                             $time, pending_results.size(), pending_results.size());
                    o_fail_count += pending_results.size();
                end
            end
        end
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for the sorted table search block: clock, reset, stimulus, sink and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 30;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 60;

    localparam logic signed [stbs_pkg::WORD_BITS-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::WORD_BITS-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n;
    logic                                    i_cfg_valid;
    logic                                    o_cfg_ready;
    logic [stbs_pkg::COUNT_BITS-1:0]         i_cfg_entry_count;
    logic                                    i_in_valid;
    logic                                    o_in_stall;
    logic                                    i_cmd;
    logic [stbs_pkg::ENTRY_INDEX_BITS-1:0]   i_entry_index;
    logic signed [stbs_pkg::WORD_BITS-1:0]   i_entry_value;
    logic signed [stbs_pkg::WORD_BITS-1:0]   i_search_key;
    logic                                    o_out_valid;
    logic                                    i_out_stall;
    logic                                    o_found;
    logic [stbs_pkg::POSITION_BITS-1:0]      o_position;
    logic                                    end_of_test;
    int                                      fail_count;

    logic signed [stbs_pkg::WORD_BITS-1:0]   shadow_values [stbs_pkg::TABLE_DEPTH_DEF];
    int                                      searches_sent = 0;
    int                                      results_taken = 0;
    int                                      quiet_cycles = 0;
    bit                                      no_idle = 1'b0;
    bit                                      hold_req = 1'b0;

    sorted_table_binary_search dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_entry_count (i_cfg_entry_count),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_entry_index     (i_entry_index),
        .i_entry_value     (i_entry_value),
        .i_search_key      (i_search_key),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_found           (o_found),
        .o_position        (o_position)
    );

    stbs_search_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_entry_count (i_cfg_entry_count),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_entry_index     (i_entry_index),
        .i_entry_value     (i_entry_value),
        .i_search_key      (i_search_key),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_found           (o_found),
        .i_position        (o_position),
        .i_end_of_test     (end_of_test),
        .o_fail_count      (fail_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_word(input logic cmd,
                             input logic [stbs_pkg::ENTRY_INDEX_BITS-1:0] idx,
                             input logic signed [stbs_pkg::WORD_BITS-1:0] val,
                             input logic signed [stbs_pkg::WORD_BITS-1:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_search_key  <= key;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_entry(input int idx,
                               input logic signed [stbs_pkg::WORD_BITS-1:0] val);
        send_word(stbs_pkg::CMD_WRITE, idx[stbs_pkg::ENTRY_INDEX_BITS-1:0], val, $urandom());
        shadow_values[idx] = val;
    endtask

    task automatic search_for(input logic signed [stbs_pkg::WORD_BITS-1:0] key);
        send_word(stbs_pkg::CMD_SEARCH,
                  stbs_pkg::ENTRY_INDEX_BITS'($urandom_range(0, stbs_pkg::TABLE_DEPTH_DEF - 1)),
                  $urandom(), key);
        searches_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (results_taken != searches_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [stbs_pkg::COUNT_BITS-1:0] count);
        i_cfg_valid       <= 1'b1;
        i_cfg_entry_count <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_sorted(input int n);
        longint acc;
        longint step_max;
        int     i;
        step_max = 64'd8589934592 / n;
        if (step_max > 64'd2147483647) begin
            step_max = 64'd2147483647;
        end
        acc = -64'sd2147483648 + $urandom_range(0, step_max[31:0]);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) != 0) begin
                acc += $urandom_range(1, step_max[31:0]);
            end
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647;
            end
            write_entry(i, acc[stbs_pkg::WORD_BITS-1:0]);
        end
    endtask

    task automatic nudge_entry(input int n);
        int                                    i;
        longint                                lo_v;
        longint                                hi_v;
        longint                                span;
        longint                                step;
        logic signed [stbs_pkg::WORD_BITS-1:0] v;
        i = $urandom_range(0, n - 1);
        lo_v = (i > 0) ? shadow_values[i-1] : shadow_values[i];
        hi_v = (i < n - 1) ? shadow_values[i+1] : shadow_values[i];
        v = shadow_values[i];
        if (hi_v > lo_v) begin
            span = hi_v - lo_v;
            step = $urandom_range(0, span[31:0]);
            span = lo_v + step;
            v = span[stbs_pkg::WORD_BITS-1:0];
        end
        write_entry(i, v);
    endtask

    function automatic logic signed [stbs_pkg::WORD_BITS-1:0] pick_key(input int n);
        int                                    sel;
        logic signed [stbs_pkg::WORD_BITS-1:0] v;
        sel = $urandom_range(0, 9);
        if (n == 0 || sel == 8) begin
            v = $urandom();
        end else if (sel == 9) begin
            case ($urandom_range(0, 3))
                0: v = VALUE_MIN;
                1: v = VALUE_MAX;
                2: v = '0;
                default: v = -1;
            endcase
        end else begin
            v = shadow_values[$urandom_range(0, n - 1)];
            if (sel == 6) begin
                v = v + 1;
            end else if (sel == 7) begin
                v = v - 1;
            end
        end
        return v;
    endfunction

    initial begin : stimulus
        int                              p;
        int                              k;
        int                              n;
        int                              pick;
        logic [stbs_pkg::COUNT_BITS-1:0] plan [PHASES];
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_entry_count <= '0;
        i_in_valid        <= 1'b0;
        i_cmd             <= stbs_pkg::CMD_WRITE;
        i_entry_index     <= '0;
        i_entry_value     <= '0;
        i_search_key      <= '0;
        end_of_test       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_entry_count(11'd1);
        write_entry(0, VALUE_MIN);
        search_for(VALUE_MIN);
        search_for(VALUE_MAX);
        search_for(0);
        settle();
        set_entry_count(11'd0);
        search_for(VALUE_MIN);
        search_for(0);
        settle();
        set_entry_count(11'd2);
        write_entry(1, VALUE_MAX);
        search_for(VALUE_MAX);
        search_for(VALUE_MIN);
        search_for(-1);
        write_entry(1, VALUE_MIN);
        search_for(VALUE_MIN);
        write_entry(0, VALUE_MAX);
        search_for(VALUE_MIN);
        search_for(VALUE_MAX);
        write_entry(stbs_pkg::TABLE_DEPTH_DEF - 1, 32'sh5555_5555);

        fill_sorted(stbs_pkg::TABLE_DEPTH_DEF);

        plan[0]  = 11'd1024;
        plan[1]  = 11'd2047;
        plan[2]  = stbs_pkg::COUNT_BITS'($urandom_range(1025, 2046));
        plan[3]  = 11'd0;
        plan[4]  = 11'd1;
        plan[5]  = 11'd2;
        plan[6]  = 11'd3;
        plan[7]  = stbs_pkg::COUNT_BITS'($urandom_range(4, 16));
        plan[8]  = stbs_pkg::COUNT_BITS'($urandom_range(17, 100));
        plan[9]  = stbs_pkg::COUNT_BITS'($urandom_range(101, 300));
        plan[10] = 11'd1024;

        for (p = 0; p < PHASES; p++) begin
            settle();
            set_entry_count(plan[p]);
            n = (plan[p] > stbs_pkg::TABLE_DEPTH_DEF) ? stbs_pkg::TABLE_DEPTH_DEF : plan[p];
            no_idle = (p == 2) || ($urandom_range(0, 5) == 0);
            if (p >= 4 && p <= 9) begin
                fill_sorted(n);
            end
            if (p == 1) begin
                hold_req = 1'b1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 1 || (pick < 3 && n == 0)) begin
                    write_entry($urandom_range(0, stbs_pkg::TABLE_DEPTH_DEF - 1), $urandom());
                end else if (pick < 3) begin
                    nudge_entry(n);
                end else begin
                    search_for(pick_key(n));
                end
            end
        end

        settle();
        end_of_test <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** sorted_table_binary_search: PASSED **");
        end else begin
            $display("** sorted_table_binary_search: FAILED **");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        i_out_stall <= 1'b1;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 3);
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** sorted_table_binary_search: FAILED **");
                $finish;
            end
        end
    end

endmodule
